// ===== src/equal_depth_binning_smoother_defines.svh =====
// Assertion macros shared by the checker.
`ifndef EQUAL_DEPTH_BINNING_SMOOTHER_DEFINES_SVH
`define EQUAL_DEPTH_BINNING_SMOOTHER_DEFINES_SVH
// Immediate implication on the same edge.
`define EDB_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication on the following edge.
`define EDB_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/edb_pkg.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother package
// Shared types, constants and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package edb_pkg;
  localparam int unsigned MaxSamplesDefault = 64;
  localparam logic [6:0] BinSizeReset = 7'd3;

  typedef struct packed {
    logic signed [23:0] sample_value;
    logic is_last;
  } edb_in_t;

  typedef struct packed {
    logic signed [23:0] sorted_value;
    logic [5:0] bin_number;
    logic signed [23:0] mean_smoothed;
    logic signed [23:0] median_smoothed;
    logic signed [23:0] boundary_smoothed;
    logic last_result;
  } edb_out_t;

  typedef enum logic [3:0] {
    BkIdle, BkSortRd, BkSortCmp, BkSortWr, BkBinInit, BkSumRd, BkSumAcc,
    BkDiv, BkMedRd, BkMedWait, BkOutRd, BkOutWait, BkOutPush
  } edb_bk_state_e;

  // Integer part truncated toward zero.
  function automatic logic signed [15:0] int_part(input logic signed [23:0] v);
    logic signed [15:0] r;
    r = v[23:8];
    if (v[23] && (v[7:0] != 8'd0)) r = r + 16'sd1;
    return r;
  endfunction
endpackage

// ===== src/edb_front.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother front
// Accepts sample beats and forwards them to the set queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module edb_front import edb_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault,
  localparam int unsigned CntW = $clog2(MaxSamples + 1)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  edb_in_t in_i,
  output logic    q_valid_o,
  output edb_in_t q_data_o,
  input  logic    q_ready_i
);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic valid_q;
  edb_in_t data_q;
  logic acc, end_set;

  assign full = valid_q && !q_ready_i;
  assign acc = push && !full;
  assign end_set = in_i.is_last || (cnt_q == CntW'(MaxSamples - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (acc) cnt_d = end_set ? '0 : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) valid_q <= 1'b1;
      else if (q_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      data_q.sample_value <= in_i.sample_value;
      data_q.is_last <= end_set;
    end
  end

  assign q_valid_o = valid_q;
  assign q_data_o = data_q;
endmodule

// ===== src/edb_div.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother divider
// Radix-2 signed divide of the bin sum by its count, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module edb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [30:0] num_i,
  input  logic [6:0]         den_i,
  output logic               done_o,
  output logic signed [23:0] quo_o
);
  logic [30:0] rem_q, quo_q;
  logic [7:0]  r_q;
  logic [4:0]  step_q;
  logic        neg_q, busy_q;
  logic [6:0]  den_q;
  logic [7:0]  trial;
  logic [30:0] qn;

  assign trial = {r_q[6:0], rem_q[30]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 5'd0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'd30) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[30];
      rem_q <= num_i[30] ? 31'(-num_i) : num_i;
      den_q <= den_i;
      r_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_q[29:0], 1'b0};
      if (!trial[7]) begin
        r_q <= trial;
        quo_q <= {quo_q[29:0], 1'b1};
      end else begin
        r_q <= {r_q[6:0], rem_q[30]};
        quo_q <= {quo_q[29:0], 1'b0};
      end
    end
  end

  assign qn = neg_q ? 31'(-quo_q) : quo_q;
  assign quo_o = qn[23:0];
  assign done_o = !busy_q && !start_i;
endmodule

// ===== src/edb_back.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother back end
// Stores a set, insertion-sorts it in memory, then emits smoothed results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module edb_back import edb_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault,
  localparam int unsigned AddrW = $clog2(MaxSamples),
  localparam int unsigned CntW = $clog2(MaxSamples + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [6:0] bin_size_i,
  input  logic       q_valid_i,
  input  edb_in_t    q_data_i,
  output logic       q_ready_o,
  output logic       res_valid_o,
  output edb_out_t   res_o,
  input  logic       res_ready_i
);
  logic signed [23:0] mem [MaxSamples];
  logic signed [23:0] rd_q;
  logic [AddrW-1:0] ra, wa;
  logic we;
  logic signed [23:0] wd;

  edb_bk_state_e st_q, st_d;
  logic [CntW-1:0] n_q, i_q, j_q, start_q, k_q, len_q;
  logic signed [23:0] key_q, lo_q, hi_q, mean_q, med_q, m1_q;
  logic signed [30:0] sum_q, sum_nx;
  logic [5:0] bin_q;
  logic [6:0] bs;
  logic div_start, div_done;
  logic signed [23:0] div_q;
  logic [CntW-1:0] rem_n, mid;
  logic signed [24:0] dlo, dhi;
  logic signed [16:0] msum;
  logic shift;

  assign bs = (bin_size_i == 7'd0) ? 7'd1 : bin_size_i;
  assign rem_n = n_q - start_q;
  assign mid = start_q + (len_q >> 1);
  assign shift = (j_q != '0) && (rd_q > key_q);
  assign sum_nx = sum_q + 31'(rd_q);

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  edb_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_nx),
    .den_i(7'(len_q)), .done_o(div_done), .quo_o(div_q)
  );

  assign q_ready_o = (st_q == BkIdle);

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:    if (q_valid_i && q_data_i.is_last) st_d = BkSortRd;
      BkSortRd:  st_d = (i_q >= n_q) ? BkBinInit : BkSortCmp;
      BkSortCmp: st_d = BkSortWr;
      BkSortWr:  st_d = shift ? BkSortWr : BkSortRd;
      BkBinInit: st_d = (start_q >= n_q) ? BkIdle : BkSumRd;
      BkSumRd:   st_d = BkSumAcc;
      BkSumAcc:  st_d = (k_q == len_q) ? BkDiv : BkSumAcc;
      BkDiv:     if (div_done) st_d = BkMedRd;
      BkMedRd:   st_d = BkMedWait;
      BkMedWait: st_d = (k_q == CntW'(2)) ? BkOutRd : BkMedWait;
      BkOutRd:   st_d = BkOutWait;
      BkOutWait: st_d = BkOutPush;
      BkOutPush: if (res_ready_i) st_d = (k_q + 1'b1 == len_q) ? BkBinInit : BkOutRd;
      default:   st_d = BkIdle;
    endcase
  end

  always_comb begin
    we = 1'b0; wd = key_q; wa = AddrW'(j_q); ra = AddrW'(i_q);
    div_start = (st_q == BkSumAcc) && (k_q == len_q);
    case (st_q)
      BkIdle: begin
        we = q_valid_i; wd = q_data_i.sample_value; wa = AddrW'(n_q);
      end
      BkSortRd:  ra = AddrW'(i_q);
      BkSortCmp: ra = AddrW'(i_q - 1'b1);
      BkSortWr: begin
        we = 1'b1;
        wa = AddrW'(j_q);
        if (shift) begin
          wd = rd_q;
          ra = AddrW'(j_q - 2'd2);
        end else begin
          wd = key_q;
        end
      end
      BkSumRd, BkSumAcc: ra = AddrW'(start_q + k_q);
      BkMedRd:   ra = AddrW'(mid - 1'b1);
      BkMedWait: ra = AddrW'(mid);
      BkOutRd, BkOutWait, BkOutPush: ra = AddrW'(start_q + k_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      n_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == BkIdle && q_valid_i) n_q <= n_q + 1'b1;
      if (st_q == BkBinInit && start_q >= n_q) n_q <= '0;
    end
  end

  assign dlo = 25'(rd_q) - 25'(lo_q);
  assign dhi = 25'(hi_q) - 25'(rd_q);
  assign msum = 17'(int_part(m1_q)) + 17'(int_part(rd_q));

  always_ff @(posedge clk_i) begin
    case (st_q)
      BkIdle: i_q <= CntW'(1);
      BkSortRd: begin
        if (i_q >= n_q) begin start_q <= '0; bin_q <= '0; end
      end
      BkSortCmp: begin
        key_q <= rd_q; j_q <= i_q;
      end
      BkSortWr: begin
        if (shift) j_q <= j_q - 1'b1;
        else i_q <= i_q + 1'b1;
      end
      BkBinInit: begin
        len_q <= (7'(rem_n) < bs) ? rem_n : CntW'(bs);
        k_q <= '0; sum_q <= '0;
      end
      BkSumRd: k_q <= k_q + 1'b1;
      BkSumAcc: begin
        sum_q <= sum_nx;
        if (k_q == CntW'(1)) lo_q <= rd_q;
        if (k_q == len_q) hi_q <= rd_q;
        else k_q <= k_q + 1'b1;
      end
      BkDiv: begin mean_q <= div_q; k_q <= '0; end
      BkMedRd: k_q <= CntW'(1);
      BkMedWait: begin
        if (k_q == CntW'(1)) begin m1_q <= rd_q; k_q <= CntW'(2); end
        else begin
          if (len_q[0]) med_q <= 24'(int_part(rd_q)) <<< 8;
          else med_q <= 24'(msum) <<< 7;
          k_q <= '0;
        end
      end
      BkOutPush: if (res_ready_i) begin
        if (k_q + 1'b1 == len_q) begin
          k_q <= '0; start_q <= start_q + len_q; bin_q <= bin_q + 1'b1;
        end else k_q <= k_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign res_valid_o = (st_q == BkOutPush);
  always_comb begin
    res_o.sorted_value = rd_q;
    res_o.bin_number = bin_q;
    res_o.mean_smoothed = mean_q;
    res_o.median_smoothed = med_q;
    res_o.boundary_smoothed = (dlo < dhi) ? lo_q : hi_q;
    res_o.last_result = (start_q + k_q + 1'b1 == n_q);
  end
endmodule

// ===== src/edb_outq.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother result register
// Holds one result beat for the consumer side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module edb_outq import edb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  edb_out_t in_i,
  output logic     in_ready_o,
  output logic     empty,
  output edb_out_t out_o,
  input  logic     pop
);
  logic v_q;
  edb_out_t d_q;
  assign in_ready_o = !v_q || pop;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (in_valid_i && in_ready_o) v_q <= 1'b1;
    else if (pop) v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) d_q <= in_i;
  end
  assign empty = !v_q;
  assign out_o = d_q;
endmodule

// ===== src/equal_depth_binning_smoother.sv =====
// Operation: a set of n samples loads one beat per cycle while the back end is
// idle, then the set is insertion-sorted in memory, then each bin is processed
// in order (sum, divide, median, results).
// Input is blocked after one held beat while a set is being processed.
// Reset (rst_ni, asynchronous, active low) clears the sample count and
// sets bin_size to 3; stored samples are undefined until written.
// ----------------------------------------------------------------------------
// Equal-depth binning smoother
// Sorts a sample set and gives mean, median and boundary smoothed values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module equal_depth_binning_smoother import edb_pkg::*; #(
  parameter int unsigned MaxSamples = MaxSamplesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  edb_in_t    in_i,
  output logic       empty,
  input  logic       pop,
  output edb_out_t   out_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);
  logic [6:0] bin_size_q;
  logic q_valid, q_ready, r_valid, r_ready;
  edb_in_t q_data;
  edb_out_t r_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_size_q <= BinSizeReset;
    else if (cfg_we_i) bin_size_q <= cfg_wdata_i;
  end

  edb_front #(.MaxSamples(MaxSamples)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_ready_i(q_ready)
  );

  edb_back #(.MaxSamples(MaxSamples)) u_back (
    .clk_i, .rst_ni, .bin_size_i(bin_size_q),
    .q_valid_i(q_valid), .q_data_i(q_data), .q_ready_o(q_ready),
    .res_valid_o(r_valid), .res_o(r_data), .res_ready_i(r_ready)
  );

  edb_outq u_outq (
    .clk_i, .rst_ni, .in_valid_i(r_valid), .in_i(r_data),
    .in_ready_o(r_ready), .empty, .out_o, .pop
  );
endmodule

// ===== src/edb_checker.sv =====
// ----------------------------------------------------------------------------
// Equal-depth binning smoother checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "equal_depth_binning_smoother_defines.svh"
module edb_checker import edb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input edb_out_t out_o
);
  `EDB_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, !empty && !pop, !empty)
  `EDB_ASSERT_NEXT(a_hold_data, clk_i, rst_ni, !empty && !pop, $stable(out_o))
  `EDB_ASSERT_IMP(a_bin_rng, clk_i, rst_ni, !empty, out_o.bin_number <= 6'd63)
endmodule

bind equal_depth_binning_smoother edb_checker u_edb_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_o
);
